@@ rtl/rtp_sequence_reorder_window_top_macros.svh @@
// Assertion macros for the RTP reorder window block.
// Used by the checker module; relies on clk and rst_n in the including scope.
`ifndef RTP_SEQUENCE_REORDER_WINDOW_TOP_MACROS_SVH
`define RTP_SEQUENCE_REORDER_WINDOW_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RTPRW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define RTPRW_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rtprw_pkg.sv @@
// Shared types and constants for the RTP reorder window block.
// No dependencies; imported by the top level and the slot reduction unit.
package rtprw_pkg;

    localparam int SEQ_W          = 16;
    localparam int HANDLE_W       = 16;
    localparam int COUNT_W        = 32;
    localparam int WINDOW_DEFAULT = 32;

    // Reciprocal scaling for the seq mod WINDOW reduction
    localparam int MOD_SHIFT = 22;

    // Stream payload layout
    localparam int S_TDATA_W = SEQ_W + HANDLE_W;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = HANDLE_W + SEQ_W + COUNT_W + COUNT_W;
    localparam int HDR_OK_BIT = 0;
    localparam int FITS_BIT   = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_MOD,
        ST_DRAIN_RD,
        ST_DRAIN_CHK,
        ST_FLUSH_SCAN,
        ST_FLUSH_OUT,
        ST_LAST
    } rtprw_state_t;

endpackage

@@ rtl/rtprw_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rtprw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rtprw_slot_mod.sv @@
// Slot index unit: reduces a sequence number modulo WINDOW, with the product
// and the slot registered, by reciprocal multiply and one correcting subtract. Depends on rtprw_pkg.
module rtprw_slot_mod #(
    parameter int WINDOW = rtprw_pkg::WINDOW_DEFAULT
) (
    input  logic                        clk,
    input  logic                        load,
    input  logic [rtprw_pkg::SEQ_W-1:0] seq,
    output logic [$clog2(WINDOW)-1:0]   slot
);

    import rtprw_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int PROD_W = SEQ_W + MOD_SHIFT;
    localparam logic [MOD_SHIFT-1:0] RECIP = MOD_SHIFT'((64'd1 << MOD_SHIFT) / WINDOW);
    localparam logic [SEQ_W-1:0]     WIN_K = SEQ_W'(WINDOW);

    logic [SEQ_W-1:0]  seq_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SEQ_W-1:0]  quot;
    logic [SEQ_W-1:0]  quot_w;
    logic [SEQ_W-1:0]  rem;
    logic [SEQ_W-1:0]  rem_fix;

    // Stage 1: scaled reciprocal product
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seq_reg  <= seq;
            prod_reg <= PROD_W'(seq) * PROD_W'(RECIP);
        end
    end

    // Stage 2: quotient estimate is exact or one low; one correction fixes it
    always_comb
    begin
        quot    = prod_reg[PROD_W-1:MOD_SHIFT];
        quot_w  = SEQ_W'(quot * WIN_K);
        rem     = seq_reg - quot_w;
        rem_fix = (rem >= WIN_K) ? (rem - WIN_K) : rem;
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= rem_fix[SLOT_W-1:0];
    end

    assign slot = slot_reg;

endmodule

@@ rtl/rtp_sequence_reorder_window_top.sv @@
// RTP reorder window: top level with the sequencer, slot mask and counters.
// Depends on rtprw_pkg, rtprw_slot_mod and rtprw_ram.
//
// Usage:
//   Slave channel s_*: one packet descriptor per transaction. s_tdata holds
//   seq_number and packet_handle; s_tuser holds header_ok and fits_slot.
//   Master channel m_*: one delivered packet per transaction, m_tlast marks
//   the final delivery caused by one input packet.
//   s_tready is high only while the sequencer is idle; a finished result may
//   still wait in the output register, so a stalled receiver holds off the
//   next packet only once a new delivery is ready to load.
//   Sequence: an accepted packet passes slot reduction and classification
//   (ST_MULT, ST_MOD). A packet that is stored or discarded then frees the
//   input. An in-order packet is then sent, and each drained slot adds a
//   slot RAM read, then compare and send. A restart scans all WINDOW slots
//   at one per cycle, stops to send each full slot, closes the scan, then
//   sends the packet itself. Invalid headers leave the sequencer idle.
//   These steps follow from the single slot RAM read port and the shared
//   modulo unit. Output stalls hold any sending step until the output is free.
//   Reset: the window is empty, not started, counters are zero, no result is
//   pending. Slot RAM contents are used only behind a set full bit.
module rtp_sequence_reorder_window_top #(
    parameter int WINDOW = rtprw_pkg::WINDOW_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rtprw_pkg::S_TDATA_W-1:0] s_tdata,  // seq_number, packet_handle
    input  logic [rtprw_pkg::S_TUSER_W-1:0] s_tuser,  // header_ok, fits_slot
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rtprw_pkg::M_TDATA_W-1:0] m_tdata,  // out_handle, out_seq, lost_total,
                                                      // received_total
    output logic [0:0]                      m_tuser,  // from_store
    output logic                            m_tlast
);

    import rtprw_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SCAN_W = $clog2(WINDOW + 1);
    localparam int ENTRY_W = SEQ_W + HANDLE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(WINDOW);
    localparam logic [SEQ_W-1:0]  WIN_SEQ   = SEQ_W'(WINDOW);

    rtprw_state_t state_reg, state_next;

    // Packet under work
    logic [SEQ_W-1:0]    in_seq_reg,    in_seq_next;
    logic [HANDLE_W-1:0] in_handle_reg, in_handle_next;
    logic                in_fits_reg,   in_fits_next;
    logic [SEQ_W-1:0]    diff_reg,      diff_next;

    // Window state
    logic [SEQ_W-1:0]    expected_reg,  expected_next;
    logic                started_reg,   started_next;
    logic [SLOT_W-1:0]   exp_slot_reg,  exp_slot_next;
    logic [WINDOW-1:0]   mask_reg,      mask_next;
    logic [COUNT_W-1:0]  loss_reg,      loss_next;
    logic [COUNT_W-1:0]  rx_reg,        rx_next;

    // Drain holding result and flush scan
    logic [HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    logic [SEQ_W-1:0]    pend_seq_reg,    pend_seq_next;
    logic                pend_store_reg,  pend_store_next;
    logic [SLOT_W-1:0]   scan_reg,        scan_next;
    logic [SCAN_W-1:0]   scan_cnt_reg,    scan_cnt_next;

    // Output register
    logic                m_valid_reg,     m_valid_next;
    logic [HANDLE_W-1:0] out_handle_reg,  out_handle_next;
    logic [SEQ_W-1:0]    out_seq_reg,     out_seq_next;
    logic                out_store_reg,   out_store_next;
    logic                out_last_reg,    out_last_next;
    logic [COUNT_W-1:0]  out_loss_reg,    out_loss_next;
    logic [COUNT_W-1:0]  out_rx_reg,      out_rx_next;

    // Control strobes
    logic                s_fire;
    logic                hdr_ok;
    logic                out_free;
    logic                emit_req;
    logic                emit_fire;
    logic                emit_store;
    logic                emit_last;
    logic [HANDLE_W-1:0] emit_handle;
    logic [SEQ_W-1:0]    emit_seq;
    logic                ram_we;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic [SEQ_W-1:0]    rd_seq;
    logic [HANDLE_W-1:0] rd_handle;
    logic                drain_match;
    logic                diff_neg;
    logic                diff_zero;
    logic                diff_in_win;
    logic [SLOT_W-1:0]   in_slot;
    logic [COUNT_W:0]    loss_sum;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : (s + SLOT_W'(1));
    endfunction

    // Slot of the new expected sequence; a 16-bit wrap lands on slot zero
    function automatic logic [SLOT_W-1:0] exp_slot_after(input logic [SLOT_W-1:0] s,
                                                         input logic [SEQ_W-1:0]  seq_new);
        return (seq_new == '0) ? '0 : slot_inc(s);
    endfunction

    assign s_fire    = s_tvalid && s_tready;
    assign hdr_ok    = s_tuser[HDR_OK_BIT];
    assign out_free  = !m_valid_reg || m_tready;
    assign emit_fire = emit_req && out_free;

    assign diff_neg    = diff_reg[SEQ_W-1];
    assign diff_zero   = (diff_reg == '0);
    assign diff_in_win = (diff_reg < WIN_SEQ);

    assign rd_seq      = ram_rdata[ENTRY_W-1:HANDLE_W];
    assign rd_handle   = ram_rdata[HANDLE_W-1:0];
    assign drain_match = mask_reg[exp_slot_reg] && (rd_seq == expected_reg);

    // Saturating loss update: adds distance minus one
    assign loss_sum = {1'b0, loss_reg} + (COUNT_W + 1)'(diff_reg - SEQ_W'(1));

    // Slot index of the packet under work
    rtprw_slot_mod #(
        .WINDOW (WINDOW)
    ) u_slot_mod (
        .clk  (clk),
        .load (s_fire),
        .seq  (s_tdata[SEQ_W-1:0]),
        .slot (in_slot)
    );

    // Slot storage: {seq, handle}
    rtprw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_slot),
        .wdata ({in_seq_reg, in_handle_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && hdr_ok)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (diff_neg)
                begin
                    state_next = ST_IDLE;
                end
                else if (diff_zero)
                begin
                    state_next = ST_DRAIN_RD;
                end
                else if (diff_in_win)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_FLUSH_SCAN;
                end
            end
            ST_DRAIN_RD:
            begin
                state_next = ST_DRAIN_CHK;
            end
            ST_DRAIN_CHK:
            begin
                if (emit_fire)
                begin
                    state_next = drain_match ? ST_DRAIN_RD : ST_IDLE;
                end
            end
            ST_FLUSH_SCAN:
            begin
                if (scan_cnt_reg == SCAN_END)
                begin
                    state_next = ST_LAST;
                end
                else if (mask_reg[scan_reg])
                begin
                    state_next = ST_FLUSH_OUT;
                end
            end
            ST_FLUSH_OUT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_FLUSH_SCAN;
                end
            end
            ST_LAST:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        emit_req    = 1'b0;
        emit_store  = 1'b0;
        emit_last   = 1'b0;
        emit_handle = pend_handle_reg;
        emit_seq    = pend_seq_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = exp_slot_reg;
        case (state_reg)
            ST_MOD:
            begin
                ram_we = !diff_neg && !diff_zero && diff_in_win && in_fits_reg;
            end
            ST_DRAIN_RD:
            begin
                ram_re = 1'b1;
            end
            ST_DRAIN_CHK:
            begin
                emit_req   = 1'b1;
                emit_store = pend_store_reg;
                emit_last  = !drain_match;
            end
            ST_FLUSH_SCAN:
            begin
                ram_raddr = scan_reg;
                ram_re    = (scan_cnt_reg != SCAN_END) && mask_reg[scan_reg];
            end
            ST_FLUSH_OUT:
            begin
                emit_req    = 1'b1;
                emit_store  = 1'b1;
                emit_handle = rd_handle;
                emit_seq    = rd_seq;
            end
            ST_LAST:
            begin
                emit_req    = 1'b1;
                emit_last   = 1'b1;
                emit_handle = in_handle_reg;
                emit_seq    = in_seq_reg;
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        in_seq_next      = in_seq_reg;
        in_handle_next   = in_handle_reg;
        in_fits_next     = in_fits_reg;
        diff_next        = diff_reg;
        expected_next    = expected_reg;
        started_next     = started_reg;
        exp_slot_next    = exp_slot_reg;
        mask_next        = mask_reg;
        loss_next        = loss_reg;
        rx_next          = rx_reg;
        pend_handle_next = pend_handle_reg;
        pend_seq_next    = pend_seq_reg;
        pend_store_next  = pend_store_reg;
        scan_next        = scan_reg;
        scan_cnt_next    = scan_cnt_reg;

        // Accept: count, start the window, take the distance
        if (s_fire && hdr_ok)
        begin
            in_seq_next    = s_tdata[SEQ_W-1:0];
            in_handle_next = s_tdata[S_TDATA_W-1:SEQ_W];
            in_fits_next   = s_tuser[FITS_BIT];
            rx_next        = (rx_reg == '1) ? rx_reg : (rx_reg + COUNT_W'(1));
            started_next   = 1'b1;
            if (started_reg)
            begin
                diff_next = s_tdata[SEQ_W-1:0] - expected_reg;
            end
            else
            begin
                expected_next = s_tdata[SEQ_W-1:0];
                diff_next     = '0;
            end
        end

        case (state_reg)
            ST_MOD:
            begin
                if (!diff_neg && diff_zero)
                begin
                    // In order: hold the packet, advance past it
                    pend_handle_next = in_handle_reg;
                    pend_seq_next    = in_seq_reg;
                    pend_store_next  = 1'b0;
                    expected_next    = in_seq_reg + SEQ_W'(1);
                    exp_slot_next    = exp_slot_after(in_slot, in_seq_reg + SEQ_W'(1));
                end
                else if (!diff_neg && diff_in_win)
                begin
                    if (in_fits_reg)
                    begin
                        mask_next[in_slot] = 1'b1;
                    end
                end
                else if (!diff_neg)
                begin
                    // Restart: flush from the old expected slot
                    scan_next     = exp_slot_reg;
                    scan_cnt_next = '0;
                    expected_next = in_seq_reg + SEQ_W'(1);
                    exp_slot_next = exp_slot_after(in_slot, in_seq_reg + SEQ_W'(1));
                    loss_next     = loss_sum[COUNT_W] ? '1 : loss_sum[COUNT_W-1:0];
                end
            end
            ST_DRAIN_CHK:
            begin
                if (emit_fire && drain_match)
                begin
                    pend_handle_next        = rd_handle;
                    pend_seq_next           = rd_seq;
                    pend_store_next         = 1'b1;
                    mask_next[exp_slot_reg] = 1'b0;
                    expected_next           = expected_reg + SEQ_W'(1);
                    exp_slot_next           = exp_slot_after(exp_slot_reg,
                                                             expected_reg + SEQ_W'(1));
                end
            end
            ST_FLUSH_SCAN:
            begin
                if ((scan_cnt_reg != SCAN_END) && !mask_reg[scan_reg])
                begin
                    scan_next     = slot_inc(scan_reg);
                    scan_cnt_next = scan_cnt_reg + SCAN_W'(1);
                end
            end
            ST_FLUSH_OUT:
            begin
                if (emit_fire)
                begin
                    mask_next[scan_reg] = 1'b0;
                    scan_next           = slot_inc(scan_reg);
                    scan_cnt_next       = scan_cnt_reg + SCAN_W'(1);
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    // Output register next values
    always_comb
    begin
        m_valid_next    = m_valid_reg;
        out_handle_next = out_handle_reg;
        out_seq_next    = out_seq_reg;
        out_store_next  = out_store_reg;
        out_last_next   = out_last_reg;
        out_loss_next   = out_loss_reg;
        out_rx_next     = out_rx_reg;
        if (emit_fire)
        begin
            m_valid_next    = 1'b1;
            out_handle_next = emit_handle;
            out_seq_next    = emit_seq;
            out_store_next  = emit_store;
            out_last_next   = emit_last;
            out_loss_next   = loss_reg;
            out_rx_next     = rx_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            expected_reg <= '0;
            started_reg  <= 1'b0;
            exp_slot_reg <= '0;
            mask_reg     <= '0;
            loss_reg     <= '0;
            rx_reg       <= '0;
            scan_reg     <= '0;
            scan_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            expected_reg <= expected_next;
            started_reg  <= started_next;
            exp_slot_reg <= exp_slot_next;
            mask_reg     <= mask_next;
            loss_reg     <= loss_next;
            rx_reg       <= rx_next;
            scan_reg     <= scan_next;
            scan_cnt_reg <= scan_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_seq_reg      <= in_seq_next;
        in_handle_reg   <= in_handle_next;
        in_fits_reg     <= in_fits_next;
        diff_reg        <= diff_next;
        pend_handle_reg <= pend_handle_next;
        pend_seq_reg    <= pend_seq_next;
        pend_store_reg  <= pend_store_next;
        out_handle_reg  <= out_handle_next;
        out_seq_reg     <= out_seq_next;
        out_store_reg   <= out_store_next;
        out_last_reg    <= out_last_next;
        out_loss_reg    <= out_loss_next;
        out_rx_reg      <= out_rx_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {out_rx_reg, out_loss_reg, out_seq_reg, out_handle_reg};
    assign m_tuser[0] = out_store_reg;
    assign m_tlast    = out_last_reg;

endmodule

@@ rtl/rtprw_checker.sv @@
// Port-level checker for the RTP reorder window, bound to the top level.
// Depends on rtp_sequence_reorder_window_top_macros.svh and rtprw_pkg.
`include "rtp_sequence_reorder_window_top_macros.svh"

module rtprw_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [rtprw_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rtprw_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [0:0]                      m_tuser,
    input logic                            m_tlast
);

    import rtprw_pkg::*;

    logic [COUNT_W-1:0] rx_seen;
    logic               bad_hdr_fire;

    assign rx_seen      = m_tdata[M_TDATA_W-1:M_TDATA_W-COUNT_W];
    assign bad_hdr_fire = s_tvalid && s_tready && !s_tuser[HDR_OK_BIT];

    // A stalled delivery holds its payload
    `RTPRW_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled delivery changed")

    // No new packet while a run still has deliveries to come
    `RTPRW_ASSERT_NOW(a_run_busy, m_tvalid && !m_tlast, !s_tready, "input ready in mid-run")

    // An invalid header leaves the block idle
    `RTPRW_ASSERT_NXT(a_bad_hdr_idle, bad_hdr_fire, s_tready, "invalid header left block busy")

    // Every delivery follows at least one counted packet
    `RTPRW_ASSERT_NOW(a_rx_nonzero, m_tvalid, rx_seen != '0, "delivery with zero receive count")

endmodule

bind rtp_sequence_reorder_window_top rtprw_checker u_rtprw_checker (.*);

@@ sim/tb_top.sv @@
// Self-checking testbench for the RTP sequence reorder window.
// Depends on rtprw_pkg and rtp_sequence_reorder_window_top (default WINDOW).
`timescale 1ns / 1ps

module tb_top;

    import rtprw_pkg::*;

    localparam int WIN          = WINDOW_DEFAULT;
    localparam int RANDOM_ITEMS = 320;
    localparam int N_DIRECTED   = 19;
    localparam int DRAIN_CYCLES = 200;

    // One delivered packet, in the field order of the result
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [SEQ_W-1:0]    seq;
        logic                from_store;
        logic                last;
        logic [COUNT_W-1:0]  lost;
        logic [COUNT_W-1:0]  recv;
    } delivery_t;

    // How a table row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } row_check_t;

    typedef struct packed {
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] handle;
        logic                ok;
        logic                fits;
        row_check_t          chk;
        delivery_t           typed;
    } stim_row_t;

    localparam delivery_t NO_DELIVERY = '0;

    // Directed table: edges of the window, drops, overwrite, drain and flush
    stim_row_t directed_rows [N_DIRECTED] = '{
        // header invalid before start: ignored
        '{16'hFFFF, 16'h0000, 1'b0, 1'b1, CHK_NONE, NO_DELIVERY},
        // first packet sets the window and is delivered at once
        '{16'hFFFE, 16'hFFFF, 1'b1, 1'b1, CHK_TYPED,
          '{16'hFFFF, 16'hFFFE, 1'b0, 1'b1, 32'd0, 32'd1}},
        // stored across the 16-bit wrap
        '{16'h0001, 16'h1111, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        // does not fit a slot: dropped
        '{16'h0000, 16'h2222, 1'b1, 1'b0, CHK_NONE, NO_DELIVERY},
        '{16'h0000, 16'h2223, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        // late packet: discarded but counted
        '{16'hFFFD, 16'h4444, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        // farthest distance that is still stored
        '{16'h001E, 16'h5555, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        // in order: drains two slots, stops at an empty one
        '{16'hFFFF, 16'h3333, 1'b1, 1'b0, CHK_MODEL, NO_DELIVERY},
        // occupied slot gets overwritten
        '{16'h0003, 16'h6666, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        '{16'h0003, 16'h7777, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        '{16'h0002, 16'h8888, 1'b1, 1'b0, CHK_MODEL, NO_DELIVERY},
        // distance equal to the window: restart with a flush
        '{16'h0024, 16'h9999, 1'b1, 1'b1, CHK_MODEL, NO_DELIVERY},
        '{16'h0026, 16'hAAAA, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        '{16'h0044, 16'hBBBB, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        // largest positive distance: flush wraps around the slots
        '{16'h8024, 16'hABCD, 1'b1, 1'b0, CHK_MODEL, NO_DELIVERY},
        // most negative distance: discarded
        '{16'h0025, 16'hCDEF, 1'b1, 1'b1, CHK_NONE, NO_DELIVERY},
        // sequence inside the window but invalid header: ignored
        '{16'h8026, 16'h1234, 1'b0, 1'b0, CHK_NONE, NO_DELIVERY},
        '{16'h8025, 16'h0000, 1'b1, 1'b0, CHK_MODEL, NO_DELIVERY},
        '{16'h8026, 16'hFFFF, 1'b1, 1'b1, CHK_MODEL, NO_DELIVERY}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    // Predictor state
    logic [SEQ_W-1:0]    win_next_seq;
    logic                win_started;
    logic [WIN-1:0]      win_full;
    logic [SEQ_W-1:0]    win_seq [WIN];
    logic [HANDLE_W-1:0] win_handle [WIN];
    logic [COUNT_W-1:0]  lost_count;
    logic [COUNT_W-1:0]  recv_count;

    delivery_t expected_deliveries [$];
    delivery_t step_deliveries [$];

    int mismatches = 0;
    int valid_sent = 0;
    int burst_left = 0;

    rtp_sequence_reorder_window_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Deliveries caused by one packet descriptor, left in step_deliveries
    task automatic predict_delivery(input logic [SEQ_W-1:0] seq,
                                    input logic [HANDLE_W-1:0] handle,
                                    input logic ok, input logic fits);
        logic [SEQ_W-1:0]   seq_delta;
        logic [COUNT_W-1:0] add;
        int                 slot;
        int                 first;
        step_deliveries.delete();
        if (!ok)
            return;
        if (recv_count != '1)
            recv_count++;
        if (!win_started)
        begin
            win_next_seq = seq;
            win_started  = 1'b1;
        end
        seq_delta = seq - win_next_seq;
        if (seq_delta[SEQ_W-1])
            return;
        if (seq_delta == '0)
        begin
            // deliver, then drain consecutive matching slots
            step_deliveries.push_back('{handle, seq, 1'b0, 1'b0, '0, '0});
            win_next_seq++;
            for (int k = 0; k < WIN; k++)
            begin
                slot = win_next_seq % WIN;
                if (!win_full[slot] || win_seq[slot] != win_next_seq)
                    break;
                step_deliveries.push_back('{win_handle[slot], win_seq[slot], 1'b1, 1'b0,
                                            '0, '0});
                win_full[slot] = 1'b0;
                win_next_seq++;
            end
        end
        else if (seq_delta < WIN)
        begin
            if (fits)
            begin
                slot             = seq % WIN;
                win_seq[slot]    = seq;
                win_handle[slot] = handle;
                win_full[slot]   = 1'b1;
            end
            return;
        end
        else
        begin
            // restart: flush every full slot from the expected one upward
            first = win_next_seq % WIN;
            add   = COUNT_W'(seq_delta) - 1;
            for (int k = 0; k < WIN; k++)
            begin
                slot = (first + k) % WIN;
                if (win_full[slot])
                    step_deliveries.push_back('{win_handle[slot], win_seq[slot], 1'b1,
                                                1'b0, '0, '0});
            end
            win_full = '0;
            step_deliveries.push_back('{handle, seq, 1'b0, 1'b0, '0, '0});
            win_next_seq = seq + 1'b1;
            if (lost_count > '1 - add)
                lost_count = '1;
            else
                lost_count = lost_count + add;
        end
        foreach (step_deliveries[i])
        begin
            step_deliveries[i].last = (i == step_deliveries.size() - 1);
            step_deliveries[i].lost = lost_count;
            step_deliveries[i].recv = recv_count;
        end
    endtask

    // One input transaction, then an optional gap between bursts
    task automatic send_packet(input logic [SEQ_W-1:0] seq,
                               input logic [HANDLE_W-1:0] handle,
                               input logic ok, input logic fits,
                               input row_check_t chk = CHK_MODEL,
                               input delivery_t typed = '0);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {handle, seq};
        s_tuser  <= {fits, ok};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (ok)
            valid_sent++;
        predict_delivery(seq, handle, ok, fits);
        if (chk != CHK_MODEL && step_deliveries.size() != (chk == CHK_TYPED ? 1 : 0))
            report_mismatch("table row result count", (chk == CHK_TYPED ? 1 : 0),
                            step_deliveries.size());
        if (chk == CHK_TYPED)
            expected_deliveries.push_back(typed);
        else if (chk == CHK_MODEL)
            foreach (step_deliveries[i])
                expected_deliveries.push_back(step_deliveries[i]);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_deliveries.size() != 0)
            @(posedge clk);
    endtask

    // One random scenario built around the current expected sequence
    task automatic random_scenario();
        int               pick;
        int               span;
        int               j;
        int               tmp;
        int               offs [$];
        logic [SEQ_W-1:0] base;
        pick = $urandom_range(0, 99);
        base = win_next_seq;
        if (pick < 25)
        begin
            // in-order run
            span = $urandom_range(1, 6);
            repeat (span)
                send_packet(win_next_seq, HANDLE_W'($urandom), 1'b1,
                            1'($urandom_range(0, 1)));
        end
        else if (pick < 62)
        begin
            // shuffled packets ahead of the window head, then the head
            span = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 8) : $urandom_range(2, WIN);
            for (int i = 1; i < span; i++)
                offs.push_back(i);
            for (int i = offs.size() - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                tmp     = offs[i];
                offs[i] = offs[j];
                offs[j] = tmp;
            end
            foreach (offs[i])
            begin
                send_packet(SEQ_W'(base + offs[i]), HANDLE_W'($urandom), 1'b1,
                            $urandom_range(0, 9) != 0);
                if ($urandom_range(0, 7) == 0)
                    send_packet(SEQ_W'(base + offs[i]), HANDLE_W'($urandom), 1'b1, 1'b1);
            end
            send_packet(base, HANDLE_W'($urandom), 1'b1, 1'($urandom_range(0, 1)));
        end
        else if (pick < 78)
        begin
            // a few stored packets, then a jump past the window
            repeat ($urandom_range(0, 5))
                send_packet(SEQ_W'(base + $urandom_range(1, WIN - 1)), HANDLE_W'($urandom),
                            1'b1, 1'b1);
            case ($urandom_range(0, 3))
                0:       span = WIN;
                1:       span = 16'h7FFF;
                default: span = $urandom_range(WIN, 16'h7FFF);
            endcase
            send_packet(SEQ_W'(win_next_seq + span), HANDLE_W'($urandom), 1'b1,
                        1'($urandom_range(0, 1)));
        end
        else if (pick < 88)
        begin
            // late or duplicate packet
            send_packet(SEQ_W'(win_next_seq - $urandom_range(1, 16'h8000)),
                        HANDLE_W'($urandom), 1'b1, 1'($urandom_range(0, 1)));
        end
        else
        begin
            // arbitrary descriptor, sometimes with a bad header
            send_packet(SEQ_W'($urandom), HANDLE_W'($urandom), $urandom_range(0, 3) != 0,
                        1'($urandom_range(0, 1)));
        end
    endtask

    // Stimulus
    initial
    begin
        win_next_seq = '0;
        win_started  = 1'b0;
        win_full     = '0;
        lost_count   = '0;
        recv_count   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_packet(directed_rows[i].seq, directed_rows[i].handle, directed_rows[i].ok,
                        directed_rows[i].fits, directed_rows[i].chk, directed_rows[i].typed);

        // hold off until every pending delivery has come out
        wait_drained();

        valid_sent = 0;
        while (valid_sent < RANDOM_ITEMS)
        begin
            random_scenario();
            if ($urandom_range(0, 29) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Receiver backpressure in phases of differing density
    int rx_mode = 0;
    int rx_left = 0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        else
            rx_left--;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ~m_tready;
        endcase
    end

    // Compare each delivered transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        delivery_t want;
        delivery_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tlast,
                    m_tdata[63:32], m_tdata[95:64]};
            if (expected_deliveries.size() == 0)
                report_mismatch("unexpected transaction, seq", '0, got.seq);
            else
            begin
                want = expected_deliveries.pop_front();
                if (got.handle != want.handle)
                    report_mismatch("out_handle", want.handle, got.handle);
                if (got.seq != want.seq)
                    report_mismatch("out_seq", want.seq, got.seq);
                if (got.from_store != want.from_store)
                    report_mismatch("from_store", want.from_store, got.from_store);
                if (got.last != want.last)
                    report_mismatch("last_of_run", want.last, got.last);
                if (got.lost != want.lost)
                    report_mismatch("lost_total", want.lost, got.lost);
                if (got.recv != want.recv)
                    report_mismatch("received_total", want.recv, got.recv);
            end
        end
    end

endmodule
